/* src/ttl_pkg.sv */
package ttl_pkg;

	// Default sizing
	localparam int CAPACITY_DEF = 32;
	localparam int KEY_BITS_DEF = 32;

	// Fixed field widths
	localparam int KEY_IN_W = 32;
	localparam int TIME_W   = 48;
	localparam int EXPIRY_W = 32;

	// Expiry window after reset, in ms
	localparam logic [EXPIRY_W-1:0] EXPIRY_RST = 32'd5000;

	// Request opcodes
	localparam logic [1:0] OP_TOUCH = 2'd0;
	localparam logic [1:0] OP_ERASE = 2'd1;
	localparam logic [1:0] OP_CLEAR = 2'd2;

	// Result status codes
	localparam logic [2:0] STATUS_HIT     = 3'd0;
	localparam logic [2:0] STATUS_CREATED = 3'd1;
	localparam logic [2:0] STATUS_FULL    = 3'd2;
	localparam logic [2:0] STATUS_ERASED  = 3'd3;
	localparam logic [2:0] STATUS_CLEARED = 3'd4;

	// One result, status in the lowest bits
	typedef struct packed {
		logic [5:0] swept_count;
		logic [5:0] entry_count;
		logic [4:0] slot;
		logic [2:0] status;
	} res_t;

	// Request sequencer
	typedef enum logic [2:0] {
		S_IDLE,
		S_SEARCH,
		S_DECIDE,
		S_SWEEP,
		S_SWEPT,
		S_RESULT
	} state_t;

endpackage

/* src/ttl_ram.sv */
module ttl_ram import ttl_pkg::*; #(
	parameter int DEPTH = CAPACITY_DEF,
	parameter int WIDTH = KEY_BITS_DEF + TIME_W,
	parameter int AW    = 5
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// One write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* src/ttl_engine.sv */
module ttl_engine import ttl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF,
	localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
	localparam int CNT_W = $clog2(CAPACITY + 1),
	localparam int KW    = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [1:0]          op,
	input  logic [KEY_IN_W-1:0] key,
	input  logic [TIME_W-1:0]   now,
	input  logic [EXPIRY_W-1:0] expiry,
	output logic                res_valid,
	input  logic                res_ready,
	output res_t                res
);

	localparam int ENT_W = KW + TIME_W;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

	state_t state_q, state_d;

	logic [1:0]          op_q;
	logic [KW-1:0]       key_q;
	logic [TIME_W-1:0]   now_q;
	logic [CAPACITY-1:0] valid_q;
	logic [CNT_W-1:0]    occ_q;
	logic [CNT_W-1:0]    swept_q;

	// Walk: read issue and compare stage
	logic             rd_on_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             cmp_s1;
	logic [IDX_W-1:0] idx_s1;

	logic             hit_q;
	logic [IDX_W-1:0] hit_idx_q;
	logic             free_q;
	logic [IDX_W-1:0] free_idx_q;
	res_t             res_q;

	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [ENT_W-1:0] mem_wdata;
	logic [ENT_W-1:0] mem_rdata;

	logic [KW-1:0]     rd_key;
	logic [TIME_W-1:0] rd_time;
	logic [TIME_W-1:0] idle;
	logic              key_eq;
	logic              expired;
	logic              last_cmp;
	logic              walk_op;

	ttl_ram #(
		.DEPTH (CAPACITY),
		.WIDTH (ENT_W),
		.AW    (IDX_W)
	) u_ram (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (rd_idx_q),
		.rdata (mem_rdata)
	);

	// Compare stage on the registered read data
	assign {rd_key, rd_time} = mem_rdata;
	assign idle     = now_q - rd_time;
	assign expired  = valid_q[idx_s1] && (idle > TIME_W'(expiry));
	assign key_eq   = valid_q[idx_s1] && (rd_key == key_q);
	assign last_cmp = cmp_s1 && (idx_s1 == LAST_IDX);
	assign walk_op  = (op == OP_TOUCH) || (op == OP_ERASE);

	assign in_ready  = (state_q == S_IDLE);
	assign res_valid = (state_q == S_RESULT);
	assign res       = res_q;

	// Entry write-back: refresh on hit, insert into a free or swept slot
	assign mem_we = ((state_q == S_DECIDE) && (op_q == OP_TOUCH) && (hit_q || free_q)) ||
		((state_q == S_SWEPT) && (swept_q != '0));
	assign mem_waddr = hit_q ? hit_idx_q : free_idx_q;
	assign mem_wdata = {key_q, now_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					state_d = walk_op ? S_SEARCH : S_DECIDE;
				end
			end
			S_SEARCH: begin
				if (last_cmp) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				if ((op_q == OP_TOUCH) && !hit_q && !free_q) begin
					state_d = S_SWEEP;
				end else begin
					state_d = S_RESULT;
				end
			end
			S_SWEEP: begin
				if (last_cmp) begin
					state_d = S_SWEPT;
				end
			end
			S_SWEPT: state_d = S_RESULT;
			S_RESULT: begin
				if (res_ready) begin
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// Request datapath, valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q       <= '0;
			key_q      <= '0;
			now_q      <= '0;
			valid_q    <= '0;
			occ_q      <= '0;
			swept_q    <= '0;
			rd_on_q    <= 1'b0;
			rd_idx_q   <= '0;
			cmp_s1     <= 1'b0;
			idx_s1     <= '0;
			hit_q      <= 1'b0;
			hit_idx_q  <= '0;
			free_q     <= 1'b0;
			free_idx_q <= '0;
			res_q      <= '0;
		end else begin
			// read walk, one entry per cycle
			cmp_s1 <= rd_on_q;
			idx_s1 <= rd_idx_q;
			if (rd_on_q) begin
				if (rd_idx_q == LAST_IDX) begin
					rd_on_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + IDX_W'(1);
				end
			end

			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						op_q  <= op;
						key_q <= KW'(key);
						now_q <= now;
						hit_q <= 1'b0;
						free_q <= 1'b0;
						swept_q <= '0;
						if (walk_op) begin
							rd_on_q  <= 1'b1;
							rd_idx_q <= '0;
						end
					end
				end
				S_SEARCH: begin
					// first matching key and lowest free slot
					if (cmp_s1) begin
						if (key_eq && !hit_q) begin
							hit_q     <= 1'b1;
							hit_idx_q <= idx_s1;
						end
						if (!valid_q[idx_s1] && !free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
				end
				S_DECIDE: begin
					// result word: swept_count, entry_count, slot, status
					case (op_q)
						OP_TOUCH: begin
							if (hit_q) begin
								res_q <= {6'd0, 6'(occ_q), 5'(hit_idx_q), STATUS_HIT};
							end else if (free_q) begin
								valid_q[free_idx_q] <= 1'b1;
								occ_q               <= occ_q + CNT_W'(1);
								res_q <= {6'd0, 6'(occ_q + CNT_W'(1)), 5'(free_idx_q),
									STATUS_CREATED};
							end else begin
								// full: sweep expired entries first
								rd_on_q  <= 1'b1;
								rd_idx_q <= '0;
								free_q   <= 1'b0;
								swept_q  <= '0;
							end
						end
						OP_ERASE: begin
							if (hit_q) begin
								valid_q[hit_idx_q] <= 1'b0;
								occ_q              <= occ_q - CNT_W'(1);
								res_q <= {6'd0, 6'(occ_q - CNT_W'(1)), 5'd0, STATUS_ERASED};
							end else begin
								res_q <= {6'd0, 6'(occ_q), 5'd0, STATUS_ERASED};
							end
						end
						OP_CLEAR: begin
							valid_q <= '0;
							occ_q   <= '0;
							res_q   <= {6'd0, 6'd0, 5'd0, STATUS_CLEARED};
						end
						default: begin
							// unused opcode answers as an erase that matched nothing
							res_q <= {6'd0, 6'(occ_q), 5'd0, STATUS_ERASED};
						end
					endcase
				end
				S_SWEEP: begin
					// drop idle entries, remember the lowest one freed
					if (cmp_s1 && expired) begin
						valid_q[idx_s1] <= 1'b0;
						swept_q         <= swept_q + CNT_W'(1);
						occ_q           <= occ_q - CNT_W'(1);
						if (!free_q) begin
							free_q     <= 1'b1;
							free_idx_q <= idx_s1;
						end
					end
				end
				S_SWEPT: begin
					if (swept_q != '0) begin
						valid_q[free_idx_q] <= 1'b1;
						occ_q               <= occ_q + CNT_W'(1);
						res_q <= {6'(swept_q), 6'(occ_q + CNT_W'(1)), 5'(free_idx_q),
							STATUS_CREATED};
					end else begin
						res_q <= {6'd0, 6'(occ_q), 5'd0, STATUS_FULL};
					end
				end
				default: ;
			endcase
		end
	end

endmodule

/* src/ttl_keyed_track_table_top.sv */
// Keyed track table with idle expiry. Each request on the s_ side touches, erases or
// clears; each gives exactly one result on the m_ side. Entries (key and last refresh
// time) live in one single-port-read synchronous RAM that is walked one entry per
// cycle; valid bits and the entry count sit in flops. Clear and the unused opcode
// need no walk. Touch and erase take one search walk; a touch that misses in a full
// table adds an expiry sweep walk. One request is in work at a time; a finished
// result waits in the output register while the next request is taken.
// expiry_ms is written through cfg_we/cfg_wdata and must only change while idle.
module ttl_keyed_track_table_top import ttl_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF,
	parameter int KEY_BITS = KEY_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,     // expiry_ms
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [87:0] s_tdata,       // opcode[1:0], track_key[33:2], now_ms[81:34]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata        // status[2:0], slot[7:3], entry_count[13:8],
	                                   // swept_count[19:14]
);

	logic [EXPIRY_W-1:0] expiry_q;
	logic                res_valid;
	logic                res_ready;
	res_t                res;
	logic                out_vld_q;
	res_t                out_q;

	// Expiry register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expiry_q <= EXPIRY_RST;
		end else if (cfg_we) begin
			expiry_q <= cfg_wdata;
		end
	end

	ttl_engine #(
		.CAPACITY (CAPACITY),
		.KEY_BITS (KEY_BITS)
	) u_engine (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.op        (s_tdata[1:0]),
		.key       (s_tdata[33:2]),
		.now       (s_tdata[81:34]),
		.expiry    (expiry_q),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res)
	);

	// Output register
	assign res_ready = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			out_q     <= '0;
		end else if (res_ready) begin
			out_vld_q <= res_valid;
			if (res_valid) begin
				out_q <= res;
			end
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {4'b0000, out_q};

endmodule

/* bench/ttl_table_checker.sv */
module ttl_table_checker import ttl_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [31:0] cfg_wdata,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [87:0] s_tdata,       // opcode[1:0], track_key[33:2], now_ms[81:34]
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [23:0] m_tdata,       // status[2:0], slot[7:3], entry_count[13:8],
	                                   // swept_count[19:14]
	output int          results_owed,
	output int          mismatches
);
	timeunit 1ns;
	timeprecision 1ps;

	// Shadow copy of the table
	logic [31:0]             ttl_window;
	logic [CAPACITY_DEF-1:0] slot_live;
	logic [31:0]             slot_key   [CAPACITY_DEF];
	logic [47:0]             slot_stamp [CAPACITY_DEF];
	int                      live_count;

	// Results still owed by the block, oldest first
	res_t owed_results[$];
	res_t got;
	res_t want;

	function automatic int find_key(input logic [31:0] key);
		for (int i = 0; i < CAPACITY_DEF; i++)
			if (slot_live[i] && slot_key[i] == key)
				return i;
		return -1;
	endfunction

	// Apply one request to the shadow table and return the result it must give
	function automatic res_t predict_table_result(input logic [1:0] op, input logic [31:0] key,
			input logic [47:0] now);
		res_t        r;
		int          s;
		int          removed;
		logic [47:0] idle;
		r = '0;
		r.status = STATUS_ERASED;
		removed = 0;
		case (op)
			OP_TOUCH: begin
				s = find_key(key);
				if (s >= 0) begin
					slot_stamp[s] = now;
					r.status = STATUS_HIT;
					r.slot = 5'(s);
				end else begin
					// expiry sweep only on a miss in a full table
					if (live_count >= CAPACITY_DEF) begin
						for (int i = 0; i < CAPACITY_DEF; i++) begin
							idle = now - slot_stamp[i];
							if (slot_live[i] && idle > {16'b0, ttl_window}) begin
								slot_live[i] = 1'b0;
								removed++;
							end
						end
						live_count -= removed;
					end
					s = -1;
					if (live_count < CAPACITY_DEF)
						for (int i = CAPACITY_DEF - 1; i >= 0; i--)
							if (!slot_live[i])
								s = i;
					if (s < 0) begin
						r.status = STATUS_FULL;
					end else begin
						slot_live[s] = 1'b1;
						slot_key[s] = key;
						slot_stamp[s] = now;
						live_count++;
						r.status = STATUS_CREATED;
						r.slot = 5'(s);
					end
				end
			end
			OP_ERASE: begin
				s = find_key(key);
				if (s >= 0) begin
					slot_live[s] = 1'b0;
					live_count--;
				end
			end
			OP_CLEAR: begin
				slot_live = '0;
				live_count = 0;
				r.status = STATUS_CLEARED;
			end
			// unused opcode: table untouched, answered like an erase that found nothing
			default: ;
		endcase
		r.entry_count = 6'(live_count);
		r.swept_count = 6'(removed);
		return r;
	endfunction

	// Watch both channels and the register port
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ttl_window = EXPIRY_RST;
			slot_live = '0;
			live_count = 0;
			owed_results.delete();
			mismatches = 0;
			results_owed <= 0;
		end else begin
			if (cfg_we)
				ttl_window = cfg_wdata;
			if (s_tvalid && s_tready)
				owed_results.push_back(predict_table_result(s_tdata[1:0], s_tdata[33:2],
					s_tdata[81:34]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[19:0];
				if (owed_results.size() == 0) begin
					$error("unexpected result %h with no request outstanding", m_tdata);
					mismatches++;
				end else begin
					want = owed_results.pop_front();
					if (got.status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, got.status);
						mismatches++;
					end
					if (got.slot !== want.slot) begin
						$error("slot: expected %0d, got %0d", want.slot, got.slot);
						mismatches++;
					end
					if (got.entry_count !== want.entry_count) begin
						$error("entry_count: expected %0d, got %0d", want.entry_count,
							got.entry_count);
						mismatches++;
					end
					if (got.swept_count !== want.swept_count) begin
						$error("swept_count: expected %0d, got %0d", want.swept_count,
							got.swept_count);
						mismatches++;
					end
				end
			end
			results_owed <= owed_results.size();
		end
	end

endmodule

/* bench/ttl_keyed_track_table_top_tb.sv */
module ttl_keyed_track_table_top_tb import ttl_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	// opcode with no function in the block
	localparam logic [1:0] OP_UNUSED = 2'd3;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        cfg_we    = 1'b0;
	logic [31:0] cfg_wdata = '0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [87:0] s_tdata   = '0;       // opcode[1:0], track_key[33:2], now_ms[81:34]
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [23:0] m_tdata;              // status[2:0], slot[7:3], entry_count[13:8],
	                                   // swept_count[19:14]

	int results_owed;
	int mismatches;

	int          send_idle_pct = 0;
	int          stall_pct     = 0;
	logic [47:0] now_ms        = '0;
	logic [31:0] ttl_cfg       = EXPIRY_RST;
	logic [31:0] key_pool [40];

	always #4 clk = ~clk;

	ttl_keyed_track_table_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata)
	);

	ttl_table_checker chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.s_tvalid     (s_tvalid),
		.s_tready     (s_tready),
		.s_tdata      (s_tdata),
		.m_tvalid     (m_tvalid),
		.m_tready     (m_tready),
		.m_tdata      (m_tdata),
		.results_owed (results_owed),
		.mismatches   (mismatches)
	);

	// Result side backpressure
	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= stall_pct);

	// Idle gap, then hold the request until it is taken
	task automatic send_request(input logic [1:0] op, input logic [31:0] key,
			input logic [47:0] t);
		int gap;
		gap = 0;
		while (gap < 30 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'b0, t, key, op};
		do @(posedge clk); while (!s_tready);
	endtask

	// Stop sending until every outstanding result is back
	task automatic drain_results();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_owed != 0);
	endtask

	initial begin
		logic [31:0] ttl_settings [5];
		logic [1:0]  op;
		logic [31:0] key;
		logic [47:0] step;
		int          r;

		ttl_settings[0] = EXPIRY_RST;
		ttl_settings[1] = '0;
		ttl_settings[2] = '1;
		ttl_settings[3] = 32'd37;
		ttl_settings[4] = $urandom_range(100, 100000);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: field extremes, each opcode, absent-key erase, wrap of time
		send_request(OP_TOUCH, 32'h0, 48'h0);
		send_request(OP_TOUCH, 32'hFFFF_FFFF, 48'h0);
		send_request(OP_TOUCH, 32'h0, 48'd5000);
		send_request(OP_ERASE, 32'd12345, 48'd5000);
		send_request(OP_ERASE, 32'h0, 48'd5001);
		send_request(OP_TOUCH, 32'hA5A5_A5A5, 48'hFFFF_FFFF_FFFF);
		send_request(OP_TOUCH, 32'hFFFF_FFFF, 48'd3);
		send_request(OP_TOUCH, 32'h5A5A_5A5A, 48'h5555_5555_5555);
		send_request(OP_TOUCH, 32'hA5A5_A5A5, 48'h0);
		send_request(OP_UNUSED, 32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF);
		send_request(OP_ERASE, 32'hFFFF_FFFF, 48'hAAAA_AAAA_AAAA);
		send_request(OP_CLEAR, 32'h0, 48'hAAAA_AAAA_AAAA);
		send_request(OP_TOUCH, 32'd7, 48'hAAAA_AAAA_AAAA);
		send_request(OP_CLEAR, 32'h0, 48'hAAAA_AAAA_AAAB);

		// Random segments: five window settings, four idling styles each
		for (int seg = 0; seg < 20; seg++) begin
			drain_results();
			repeat (8) @(posedge clk);
			if (seg % 4 == 0) begin
				ttl_cfg = ttl_settings[seg / 4];
				cfg_wdata <= ttl_cfg;
				cfg_we <= 1'b1;
				@(posedge clk);
				cfg_we <= 1'b0;
				// a pool a bit wider than the table, so it fills and sweeps
				foreach (key_pool[i])
					key_pool[i] = $urandom;
				key_pool[0] = '0;
				key_pool[1] = '1;
				now_ms = 48'({$urandom, $urandom});
			end
			case (seg % 4)
				0: begin
					send_idle_pct <= 0;
					stall_pct <= 0;
				end
				1: begin
					send_idle_pct <= 79;
					stall_pct <= 0;
				end
				2: begin
					send_idle_pct <= 0;
					stall_pct <= 79;
				end
				default: begin
					send_idle_pct <= 7;
					stall_pct <= 7;
				end
			endcase

			for (int k = 0; k < 85; k++) begin
				r = $urandom_range(99);
				if (r < 90)
					op = OP_TOUCH;
				else if (r < 98)
					op = OP_ERASE;
				else if (r < 99)
					op = OP_CLEAR;
				else
					op = OP_UNUSED;
				if ($urandom_range(99) < 5)
					key = $urandom;
				else
					key = key_pool[$urandom_range(39)];

				// clock steps: bursts at one time, short hops, jumps right at the window
				// edge, and now and then a step back or a jump anywhere
				r = $urandom_range(99);
				if (r < 30)
					step = '0;
				else if (r < 65)
					step = 48'($urandom_range(1, 40));
				else if (r < 85)
					step = 48'($urandom_range(0, ttl_cfg >> 3));
				else if (r < 90)
					step = {16'b0, ttl_cfg};
				else
					step = {16'b0, ttl_cfg} + 48'd1;
				if (r >= 97)
					now_ms = 48'({$urandom, $urandom});
				else if (r >= 94)
					now_ms = now_ms - 48'($urandom_range(1, 2000));
				else
					now_ms = now_ms + step;

				send_request(op, key, now_ms);
			end
		end

		drain_results();
		repeat (80) @(posedge clk);
		if (mismatches == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	// Watchdog
	initial begin
		#10_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
